/* hw/rtl/pwm_charge_throttle_and_cell_balance_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the charge throttle / cell balance unit
// Shared concurrent assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PWM_CHARGE_THROTTLE_AND_CELL_BALANCE_UNIT_MACROS_SVH
`define PWM_CHARGE_THROTTLE_AND_CELL_BALANCE_UNIT_MACROS_SVH

// same-cycle implication
`define PCTCB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pctcb assertion failed");

// next-cycle implication
`define PCTCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pctcb assertion failed");

`endif

/* hw/rtl/pctcb_pkg.sv */
// ----------------------------------------------------------------------------
// pctcb_pkg
// Types and constants for the charge throttle / cell balance unit.
// ----------------------------------------------------------------------------
package pctcb_pkg;

    localparam int VOLT_W      = 10;
    localparam int DUTY_W      = 16;
    localparam int CELL_INPUTS = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [VOLT_W-1:0] CELL_HIGH_LIMIT_RST = 10'd1023;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_HIGH_LIMIT = 3'd0,
        CFG_BLEED_FLOOR     = 3'd1,
        CFG_PV_LOW_LEVEL    = 3'd2,
        CFG_PV_MPP_LEVEL    = 3'd3,
        CFG_DUTY_CEILING    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [VOLT_W-1:0] cell_high_limit;
        logic [VOLT_W-1:0] bleed_floor;
        logic [VOLT_W-1:0] pv_low_level;
        logic [VOLT_W-1:0] pv_mpp_level;
        logic [DUTY_W-1:0] duty_ceiling;
    } cfg_regs_t;

    typedef struct packed {
        logic [VOLT_W-1:0] cell0_volts;
        logic [VOLT_W-1:0] cell1_volts;
        logic [VOLT_W-1:0] cell2_volts;
        logic [VOLT_W-1:0] cell3_volts;
        logic [VOLT_W-1:0] pv_volts;
        logic              battery_full;
        logic [1:0]        highest_cell;
    } in_word_t;

    typedef struct packed {
        logic [DUTY_W-1:0]      duty_count;
        logic [CELL_INPUTS-1:0] bleed_active;
        logic [CELL_INPUTS-1:0] gate_drive;
    } out_word_t;

endpackage

/* hw/rtl/pwm_charge_throttle_and_cell_balance_unit.sv */
// Pipeline: 2 stages (input reg, result reg); an accepted word goes to the input register,
// then to the result register, which drives out_*. Throughput: one word per cycle while
// out_ready keeps up; the duty/bleed update is a single compare-and-step pass.
// in_ready drops only while both registers are full and out_ready is low.
// Reset (rst_n, async, active low): duty count 0, all bleed flags 0, cell_high_limit 1023,
// other config registers 0, both pipeline registers empty.
// ----------------------------------------------------------------------------
// pwm_charge_throttle_and_cell_balance_unit
// Charge throttle PWM duty counter plus passive cell balancing with hysteresis.
// ----------------------------------------------------------------------------
module pwm_charge_throttle_and_cell_balance_unit
    import pctcb_pkg::*;
#(
    parameter int NUM_CELLS = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input word channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_word,
    // result word channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_word
);

    // cells actually handled: clamp to the four cell inputs, at least one
    localparam int CELL_COUNT = (NUM_CELLS > CELL_INPUTS) ? CELL_INPUTS :
                                ((NUM_CELLS < 1) ? 1 : NUM_CELLS);

    cfg_regs_t cfg;

    // stage 1: input register
    logic     s1_valid_reg;
    in_word_t s1_word_reg;

    // stage 2: result register
    logic      out_valid_reg;
    out_word_t out_word_reg;
    out_word_t out_word_next;

    logic                   advance;
    logic [DUTY_W-1:0]      duty_next;
    logic [CELL_INPUTS-1:0] bleed_next;

    // The held word is processed (and state updated) only when the result
    // register can take it, so state steps exactly once per delivered word.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    pctcb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pctcb_duty #(
        .CELL_COUNT (CELL_COUNT)
    ) u_duty (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .word      (s1_word_reg),
        .cfg       (cfg),
        .duty_next (duty_next)
    );

    pctcb_bleed #(
        .CELL_COUNT (CELL_COUNT)
    ) u_bleed (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .word       (s1_word_reg),
        .cfg        (cfg),
        .bleed_next (bleed_next)
    );

    // Cell 0 gate is active low; the rest follow their bleed bits.
    always_comb
    begin
        out_word_next.duty_count   = duty_next;
        out_word_next.bleed_active = bleed_next;
        out_word_next.gate_drive   = bleed_next ^ CELL_INPUTS'(1);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_word_reg <= in_word;
        if (advance)
            out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

/* hw/rtl/pctcb_cfg.sv */
// ----------------------------------------------------------------------------
// pctcb_cfg
// Configuration register file, write-only.
// ----------------------------------------------------------------------------
module pctcb_cfg
    import pctcb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_regs_t             cfg
);

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CELL_HIGH_LIMIT: cfg_next.cell_high_limit = cfg_data[VOLT_W-1:0];
                CFG_BLEED_FLOOR:     cfg_next.bleed_floor     = cfg_data[VOLT_W-1:0];
                CFG_PV_LOW_LEVEL:    cfg_next.pv_low_level    = cfg_data[VOLT_W-1:0];
                CFG_PV_MPP_LEVEL:    cfg_next.pv_mpp_level    = cfg_data[VOLT_W-1:0];
                CFG_DUTY_CEILING:    cfg_next.duty_ceiling    = cfg_data[DUTY_W-1:0];
                default:             cfg_next = cfg_reg; // unknown index: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_high_limit <= CELL_HIGH_LIMIT_RST;
            cfg_reg.bleed_floor     <= '0;
            cfg_reg.pv_low_level    <= '0;
            cfg_reg.pv_mpp_level    <= '0;
            cfg_reg.duty_ceiling    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/pctcb_duty.sv */
// ----------------------------------------------------------------------------
// pctcb_duty
// Saturating up/down PWM duty counter.
// ----------------------------------------------------------------------------
module pctcb_duty
    import pctcb_pkg::*;
#(
    parameter int CELL_COUNT = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  in_word_t          word,
    input  cfg_regs_t         cfg,
    output logic [DUTY_W-1:0] duty_next
);

    logic [DUTY_W-1:0] duty_reg;
    logic [VOLT_W-1:0] cell_v [CELL_INPUTS];
    logic              cell_high;
    logic              rise;

    assign cell_v[0] = word.cell0_volts;
    assign cell_v[1] = word.cell1_volts;
    assign cell_v[2] = word.cell2_volts;
    assign cell_v[3] = word.cell3_volts;

    always_comb
    begin
        cell_high = (int'(word.highest_cell) < CELL_COUNT) &&
                    (cell_v[word.highest_cell] >= cfg.cell_high_limit);
        rise = (cell_high || (word.pv_volts < cfg.pv_mpp_level) || word.battery_full) &&
               (duty_reg < cfg.duty_ceiling);
        if (rise)
            duty_next = duty_reg + 1'b1;     // below ceiling, cannot wrap
        else if (duty_reg != '0)
            duty_next = duty_reg - 1'b1;
        else
            duty_next = duty_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            duty_reg <= '0;
        else if (step)
            duty_reg <= duty_next;
    end

endmodule

/* hw/rtl/pctcb_bleed.sv */
// ----------------------------------------------------------------------------
// pctcb_bleed
// Per-cell bleed hysteresis flags.
// ----------------------------------------------------------------------------
module pctcb_bleed
    import pctcb_pkg::*;
#(
    parameter int CELL_COUNT = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  in_word_t               word,
    input  cfg_regs_t              cfg,
    output logic [CELL_INPUTS-1:0] bleed_next
);

    logic [CELL_INPUTS-1:0] bleed_reg;
    logic [VOLT_W-1:0]      cell_v [CELL_INPUTS];
    logic                   pv_ok;

    assign cell_v[0] = word.cell0_volts;
    assign cell_v[1] = word.cell1_volts;
    assign cell_v[2] = word.cell2_volts;
    assign cell_v[3] = word.cell3_volts;
    assign pv_ok     = word.pv_volts >= cfg.pv_low_level;

    // start test first, then stop test, same tick
    always_comb
    begin
        for (int i = 0; i < CELL_INPUTS; i++)
        begin
            if (i >= CELL_COUNT)
                bleed_next[i] = 1'b0;
            else
                bleed_next[i] = (bleed_reg[i] ||
                                 ((cell_v[i] >= cfg.cell_high_limit) && pv_ok)) &&
                                !((cell_v[i] < cfg.bleed_floor) || !pv_ok ||
                                  word.battery_full);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bleed_reg <= '0;
        else if (step)
            bleed_reg <= bleed_next;
    end

endmodule

/* hw/rtl/pctcb_checker.sv */
// ----------------------------------------------------------------------------
// pctcb_checker
// Port-level checks for the charge throttle / cell balance unit.
// ----------------------------------------------------------------------------
`include "pwm_charge_throttle_and_cell_balance_unit_macros.svh"

module pctcb_checker
    import pctcb_pkg::*;
#(
    parameter int NUM_CELLS = 4
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input out_word_t             out_word
);

    localparam int CELL_COUNT = (NUM_CELLS > CELL_INPUTS) ? CELL_INPUTS :
                                ((NUM_CELLS < 1) ? 1 : NUM_CELLS);

    logic [CELL_INPUTS-1:0] absent_mask;
    logic                   out_stall;
    logic                   gate0_ok;
    logic                   gate_hi_ok;
    logic                   absent_idle;

    always_comb
    begin
        for (int i = 0; i < CELL_INPUTS; i++)
            absent_mask[i] = (i >= CELL_COUNT);
    end

    assign out_stall   = out_valid && !out_ready;
    assign gate0_ok    = out_word.gate_drive[0] != out_word.bleed_active[0];
    assign gate_hi_ok  = out_word.gate_drive[CELL_INPUTS-1:1] ==
                         out_word.bleed_active[CELL_INPUTS-1:1];
    assign absent_idle = (out_word.bleed_active & absent_mask) == '0;

    // stalled result word holds
    `PCTCB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_word))
    // input side only backs up behind a stalled result word
    `PCTCB_ASSERT_IMPLY(a_in_stall, clk, rst_n, !in_ready, out_stall)
    // cell 0 gate pin is the inverse of its bleed bit
    `PCTCB_ASSERT_IMPLY(a_gate0_inv, clk, rst_n, out_valid, gate0_ok)
    // upper gate pins follow their bleed bits
    `PCTCB_ASSERT_IMPLY(a_gate_hi, clk, rst_n, out_valid, gate_hi_ok)
    // cells that do not exist never bleed
    `PCTCB_ASSERT_IMPLY(a_absent_idle, clk, rst_n, out_valid, absent_idle)

endmodule

bind pwm_charge_throttle_and_cell_balance_unit pctcb_checker #(
    .NUM_CELLS (NUM_CELLS)
) u_pctcb_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the charge throttle / cell balance unit. A short
// table of hand-written words (some with their results typed in) is followed
// by random phases under several register settings. Every result word is
// compared field by field with its typed result or with an in-bench model of
// the duty counter and the bleed hysteresis.
// ----------------------------------------------------------------------------
module tb;
    import pctcb_pkg::*;

    localparam int CELLS        = 4;
    localparam int VOLT_MAX     = 1023;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 200;
    localparam int HOLD_CYCLES  = 300;      // receiver hold-off in the pressure phase
    localparam int DRAIN_CYCLES = 2000;     // bound on waiting for results to come back
    localparam int TAIL_CYCLES  = 10;       // pipeline is 2 deep; watch a few more edges
    localparam longint RUN_LIMIT_NS = 10_000_000;

    // register indexes the block does not decode; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    // gate pin of cell 0 is active low, the others follow their bleed flag
    localparam logic [CELL_INPUTS-1:0] GATE_INVERT = 4'b0001;

    typedef enum logic [1:0] {
        ROW_WORD,       // result comes from the model
        ROW_TYPED,      // result typed into the table
        ROW_CFG         // register write, issued while the block is idle
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        in_word_t              word;
        out_word_t             result;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_word_t              in_word = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_word_t             out_word;

    // bench-side copy of the block state and registers
    cfg_regs_t             cfg_model;
    logic [DUTY_W-1:0]     duty_model;
    logic [CELL_INPUTS-1:0] bleed_model;

    out_word_t             pending_results[$];
    stim_row_t             directed_rows[$];
    int                    mismatch_count = 0;

    // traffic shaping, set by the main sequence; idle_on is read on both channels, pressure_on on the result side
    logic                  idle_on = 1'b1;
    logic                  pressure_on = 1'b0;

    pwm_charge_throttle_and_cell_balance_unit #(
        .NUM_CELLS (CELLS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hard stop in case a handshake hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void reset_model();
        cfg_model                 = '0;
        cfg_model.cell_high_limit = CELL_HIGH_LIMIT_RST;
        duty_model                = '0;
        bleed_model               = '0;
    endfunction

    // One control tick: duty counter step first, then bleed start/stop per cell.
    function automatic out_word_t balance_tick(input in_word_t w);
        logic [VOLT_W-1:0] volts [CELL_INPUTS];
        logic              over_limit;
        logic              rise;
        out_word_t         r;
        volts[0] = w.cell0_volts;
        volts[1] = w.cell1_volts;
        volts[2] = w.cell2_volts;
        volts[3] = w.cell3_volts;

        // a highest-cell index that names no existing cell never throttles
        over_limit = (int'(w.highest_cell) < CELLS) &&
                     (volts[w.highest_cell] >= cfg_model.cell_high_limit);
        rise = (over_limit || (w.pv_volts < cfg_model.pv_mpp_level) || w.battery_full) &&
               (duty_model < cfg_model.duty_ceiling);
        if (rise)
            duty_model = duty_model + 1'b1;
        else if (duty_model != '0)
            duty_model = duty_model - 1'b1;

        for (int i = 0; i < CELL_INPUTS; i++)
        begin
            if (i >= CELLS)
                bleed_model[i] = 1'b0;
            else
            begin
                if (!bleed_model[i] && (volts[i] >= cfg_model.cell_high_limit) &&
                    (w.pv_volts >= cfg_model.pv_low_level))
                    bleed_model[i] = 1'b1;
                // stop test runs after start, so both can hit in one tick
                if (bleed_model[i] && ((volts[i] < cfg_model.bleed_floor) ||
                    (w.pv_volts < cfg_model.pv_low_level) || w.battery_full))
                    bleed_model[i] = 1'b0;
            end
        end

        r.duty_count   = duty_model;
        r.bleed_active = bleed_model;
        r.gate_drive   = bleed_model ^ GATE_INVERT;
        return r;
    endfunction

    // Register write, with the enable up for one cycle and then down again.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_CELL_HIGH_LIMIT: cfg_model.cell_high_limit = data[VOLT_W-1:0];
            CFG_BLEED_FLOOR:     cfg_model.bleed_floor     = data[VOLT_W-1:0];
            CFG_PV_LOW_LEVEL:    cfg_model.pv_low_level    = data[VOLT_W-1:0];
            CFG_PV_MPP_LEVEL:    cfg_model.pv_mpp_level    = data[VOLT_W-1:0];
            CFG_DUTY_CEILING:    cfg_model.duty_ceiling    = data[DUTY_W-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one word, with random idle cycles ahead of it, and log its result
    // once the block takes it.
    task automatic send_word(input in_word_t w, input logic typed,
                             input out_word_t typed_result);
        out_word_t modeled;
        while (idle_on && ($urandom_range(99) < 19))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // model always steps so its state stays in line with the block
        modeled = balance_tick(w);
        pending_results.push_back(typed ? typed_result : modeled);
    endtask

    // Stop offering and wait for every outstanding result word.
    task automatic drain_results();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while ((pending_results.size() != 0) && (waited < DRAIN_CYCLES))
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d result words never arrived",
                                      pending_results.size()));
            pending_results.delete();
        end
    endtask

    function automatic in_word_t make_word(input logic [VOLT_W-1:0] c0,
                                           input logic [VOLT_W-1:0] c1,
                                           input logic [VOLT_W-1:0] c2,
                                           input logic [VOLT_W-1:0] c3,
                                           input logic [VOLT_W-1:0] pv,
                                           input logic full,
                                           input logic [1:0] top);
        in_word_t w;
        w.cell0_volts  = c0;
        w.cell1_volts  = c1;
        w.cell2_volts  = c2;
        w.cell3_volts  = c3;
        w.pv_volts     = pv;
        w.battery_full = full;
        w.highest_cell = top;
        return w;
    endfunction

    function automatic void add_word(input in_word_t w);
        stim_row_t r;
        r        = '{kind: ROW_WORD, word: w, result: '0, index: '0, data: '0};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_typed(input in_word_t w, input out_word_t res);
        stim_row_t r;
        r        = '{kind: ROW_TYPED, word: w, result: res, index: '0, data: '0};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r        = '{kind: ROW_CFG, word: '0, result: '0, index: idx, data: data};
        directed_rows.push_back(r);
    endfunction

    // Voltages cluster around the programmed thresholds so the compares flip often.
    function automatic logic [VOLT_W-1:0] pick_volts();
        int mark;
        int v;
        case ($urandom_range(4))
            0: mark = cfg_model.cell_high_limit;
            1: mark = cfg_model.bleed_floor;
            2: mark = cfg_model.pv_low_level;
            3: mark = cfg_model.pv_mpp_level;
            default: return VOLT_W'($urandom_range(VOLT_MAX));
        endcase
        v = mark + int'($urandom_range(4)) - 2;
        if (v < 0)
            v = 0;
        if (v > VOLT_MAX)
            v = VOLT_MAX;
        return VOLT_W'(v);
    endfunction

    function automatic in_word_t random_word();
        return make_word(pick_volts(), pick_volts(), pick_volts(), pick_volts(),
                         pick_volts(), ($urandom_range(99) < 15),
                         2'($urandom_range(3)));
    endfunction

    // Settings for one random phase: the first three are the register extremes,
    // the rest random. Ceilings are mostly small so the counter saturates, and a
    // small one after a large one leaves the count above the ceiling.
    task automatic apply_settings(input int phase);
        logic [VOLT_W-1:0] lim;
        logic [VOLT_W-1:0] flr;
        logic [VOLT_W-1:0] pvl;
        logic [VOLT_W-1:0] mpp;
        logic [DUTY_W-1:0] ceil;
        case (phase)
            0:
            begin
                lim = '0; flr = '0; pvl = '0; mpp = '0; ceil = '0;
            end
            1:
            begin
                lim = '1; flr = '1; pvl = '1; mpp = '1; ceil = '1;
            end
            2:
            begin
                lim = '0; flr = '1; pvl = '0; mpp = '1; ceil = '1;
            end
            default:
            begin
                lim  = VOLT_W'($urandom_range(VOLT_MAX));
                flr  = VOLT_W'($urandom_range(VOLT_MAX));
                pvl  = VOLT_W'($urandom_range(VOLT_MAX));
                mpp  = VOLT_W'($urandom_range(VOLT_MAX));
                ceil = ($urandom_range(3) == 0) ? DUTY_W'($urandom) :
                                                  DUTY_W'($urandom_range(24));
            end
        endcase
        drain_results();
        // unused upper data bits carry junk; the 10-bit registers must drop them
        write_reg(CFG_CELL_HIGH_LIMIT, {6'($urandom), lim});
        write_reg(CFG_BLEED_FLOOR,     {6'($urandom), flr});
        write_reg(CFG_PV_LOW_LEVEL,    {6'($urandom), pvl});
        write_reg(CFG_PV_MPP_LEVEL,    {6'($urandom), mpp});
        write_reg(CFG_DUTY_CEILING,    ceil);
        write_reg(CFG_IDX_W'(CFG_SPARE_FIRST + $urandom_range(CFG_SPARE_LAST - CFG_SPARE_FIRST)),
                  CFG_DATA_W'($urandom));
    endtask

    // Result side: check every accepted word, then pick out_ready for the next
    // edge. The pressure phase holds ready low for a long stretch so the block
    // fills both pipeline stages and drops in_ready.
    initial
    begin
        int        hold_left;
        logic      pressure_seen;
        out_word_t want;
        hold_left     = 0;
        pressure_seen = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result word with nothing pending");
                else
                begin
                    want = pending_results.pop_front();
                    if (out_word.duty_count !== want.duty_count)
                        report_mismatch($sformatf("duty_count got %0d want %0d",
                                                  out_word.duty_count, want.duty_count));
                    if (out_word.bleed_active !== want.bleed_active)
                        report_mismatch($sformatf("bleed_active got %b want %b",
                                                  out_word.bleed_active, want.bleed_active));
                    if (out_word.gate_drive !== want.gate_drive)
                        report_mismatch($sformatf("gate_drive got %b want %b",
                                                  out_word.gate_drive, want.gate_drive));
                end
            end
            if (pressure_on && !pressure_seen)
            begin
                pressure_seen = 1'b1;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on)
                out_ready <= ($urandom_range(99) >= 19);
            else
                out_ready <= 1'b1;
        end
    end

    // Main sequence: reset, directed table, random phases, final verdict.
    initial
    begin
        reset_model();

        // --- directed table --------------------------------------------------
        // Straight after reset: limit 1023, floor 0, PV levels 0, ceiling 0, so
        // the duty count is pinned at 0 and only a reading of 1023 starts a bleed.
        add_typed(make_word(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 2'd0),
                  {16'd0, 4'b0000, 4'b0001});
        add_typed(make_word(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0, 2'd3),
                  {16'd0, 4'b1111, 4'b1110});
        // battery full stops every bleed
        add_typed(make_word(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1, 2'd3),
                  {16'd0, 4'b0000, 4'b0001});
        add_typed(make_word(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0, 2'd0),
                  {16'd0, 4'b1111, 4'b1110});
        // hysteresis: nothing drops below a floor of 0, so bleeding holds
        add_typed(make_word(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 2'd1),
                  {16'd0, 4'b1111, 4'b1110});

        add_cfg(CFG_CELL_HIGH_LIMIT, 16'hFC00 | 16'd600);
        add_cfg(CFG_BLEED_FLOOR,     16'd400);
        add_cfg(CFG_PV_LOW_LEVEL,    16'd300);
        add_cfg(CFG_PV_MPP_LEVEL,    16'd700);
        add_cfg(CFG_DUTY_CEILING,    16'd3);
        add_cfg(CFG_SPARE_FIRST,     16'hFFFF);
        add_cfg(CFG_SPARE_LAST,      16'h0000);
        // rise by battery full, by low PV, by the named cell at the limit
        add_word(make_word(10'd100, 10'd100, 10'd100, 10'd100, 10'd800, 1'b1, 2'd0));
        add_word(make_word(10'd500, 10'd500, 10'd500, 10'd500, 10'd500, 1'b0, 2'd2));
        add_word(make_word(10'd500, 10'd500, 10'd600, 10'd500, 10'd800, 1'b0, 2'd2));
        // ceiling reached: rise blocked
        add_word(make_word(10'd500, 10'd500, 10'd600, 10'd500, 10'd800, 1'b0, 2'd2));
        // cell 2 sits on the floor, then drops under it
        add_word(make_word(10'd500, 10'd500, 10'd400, 10'd500, 10'd800, 1'b0, 2'd2));
        add_word(make_word(10'd500, 10'd500, 10'd399, 10'd500, 10'd800, 1'b0, 2'd2));
        // PV just below, at, then below the low level
        add_word(make_word(10'd500, 10'd1023, 10'd500, 10'd500, 10'd299, 1'b0, 2'd1));
        add_word(make_word(10'd500, 10'd1023, 10'd500, 10'd500, 10'd300, 1'b0, 2'd1));
        add_word(make_word(10'd500, 10'd1023, 10'd500, 10'd500, 10'd299, 1'b0, 2'd1));
        // start and stop in one tick through battery full
        add_word(make_word(10'd500, 10'd500, 10'd500, 10'd1023, 10'd1023, 1'b1, 2'd3));

        // limit under the floor: a reading between them starts and stops at once
        add_cfg(CFG_BLEED_FLOOR,     16'd800);
        add_cfg(CFG_CELL_HIGH_LIMIT, 16'd200);
        add_cfg(CFG_DUTY_CEILING,    16'hFFFF);
        add_word(make_word(10'd500, 10'd0, 10'd0, 10'd0, 10'd1023, 1'b0, 2'd0));
        add_word(make_word(10'd900, 10'd0, 10'd0, 10'd0, 10'd1023, 1'b0, 2'd0));
        add_word(make_word(10'd900, 10'd0, 10'd0, 10'd0, 10'd1023, 1'b1, 2'd0));
        add_word(make_word(10'd900, 10'd0, 10'd0, 10'd0, 10'd1023, 1'b1, 2'd0));
        add_word(make_word(10'd900, 10'd0, 10'd0, 10'd0, 10'd1023, 1'b1, 2'd0));
        // ceiling dropped under the count: it must fall even with a rise request
        add_cfg(CFG_DUTY_CEILING,    16'd0);
        add_word(make_word(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, 2'd0));
        add_word(make_word(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd0, 1'b1, 2'd3));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(directed_rows[k].index, directed_rows[k].data);
            end
            else
                send_word(directed_rows[k].word, directed_rows[k].kind == ROW_TYPED,
                          directed_rows[k].result);
        end

        // --- random phases ---------------------------------------------------
        // Phase 3 runs with no idling on either side; phase 5 carries the long
        // receiver hold-off while words keep coming.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            apply_settings(phase);
            idle_on = (phase != 3);
            if (phase == 5)
                pressure_on = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(random_word(), 1'b0, '0);
        end
        idle_on = 1'b1;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("result words still pending at the end");

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
